FILE: hdl/psvb_pkg.sv
// ----------------------------------------------------------------------------
// psvb_pkg
// shared types, constants and the sine table builder for the voice bank
// ----------------------------------------------------------------------------
package psvb_pkg;

   localparam int NUM_VOICES_DEF      = 16;
   localparam int SINE_TABLE_BITS_DEF = 10;

   localparam logic [9:0]  RAMP_RESET      = 10'd353;
   localparam logic [31:0] LEVEL_EPS       = 32'd21475;
   localparam logic [14:0] TARGET_FREE_MAX = 15'd3;
   localparam logic [31:0] LEVEL_FREE_MAX  = 32'd214748;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_SET     = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;
   localparam logic [1:0] ACT_CLEAR   = 2'd3;

   localparam logic [0:0] CSR_RAMP = 1'b0;

   // controller -> datapath commands
   typedef struct packed {
      logic load;       // capture item fields, clear accumulator
      logic scan_step;  // look at slot at scan pointer (key search)
      logic apply_set;  // write step/target (and init when new)
      logic apply_rel;  // release found slot
      logic clear_all;  // free every slot
      logic div_start;  // start level divide for current voice
      logic div_step;   // one divider iteration
      logic voice_fin;  // update level/phase, add contribution
      logic next_voice; // advance voice pointer
      logic finish;     // emit result
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic cur_used;
      logic need_div;
      logic div_done;
      logic last_voice;
   } stat_type;

   // shift-subtract quotient, only used while building the table
   function automatic longint unsigned table_udiv(input longint unsigned a,
                                                  input longint unsigned d);
      longint unsigned q, r;
      q = 64'd0;
      r = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         r = (r << 1) | ((a >> b) & 64'd1);
         if (r >= d) begin
            r = r - d;
            q = q | (64'd1 << b);
         end
      end
      return q;
   endfunction

   // sine magnitude of k*(pi/2)/2^qbits, Q1.15
   function automatic int quarter_sine(input longint unsigned k, input int qbits);
      longint unsigned x, x2, term, v;
      longint sum;
      x = (k * PI_HALF_Q30 + (64'd1 << (qbits - 1))) >> qbits;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 6; n++) begin
         term = table_udiv((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
         if ((n & 1) == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      return int'(v);
   endfunction

   function automatic logic signed [15:0] sine_entry(input int i, input int bits);
      int qbits, quarter, q, r, m;
      qbits = bits - 2;
      quarter = 1 << qbits;
      q = i >> qbits;
      r = i & (quarter - 1);
      m = ((q & 1) == 1) ? quarter_sine(64'(quarter - r), qbits)
                         : quarter_sine(64'(r), qbits);
      return ((q & 2) != 0) ? 16'(-m) : 16'(m);
   endfunction

endpackage

FILE: hdl/psvb_ctrl.sv
// ----------------------------------------------------------------------------
// psvb_ctrl
// sequencer for item handling: key scan, per-voice tick loop, result strobe
// ----------------------------------------------------------------------------
module psvb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_action,
   input  psvb_pkg::stat_type   stat,
   output psvb_pkg::cmd_type    cmd,
   output logic                 busy
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SCAN  = 8'b0000_0010,
      ST_APPLY = 8'b0000_0100,
      ST_VOICE = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_FIN   = 8'b0010_0000,
      ST_DONE  = 8'b0100_0000,
      ST_CLR   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] act_ff, act_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         act_ff   <= psvb_pkg::ACT_TICK;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               act_in   = req_action;
               case (req_action)
                  psvb_pkg::ACT_TICK:  state_in = ST_VOICE;
                  psvb_pkg::ACT_CLEAR: state_in = ST_CLR;
                  default:             state_in = ST_SCAN;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_step  = 1'b1;
            cmd.next_voice = 1'b1;
            if (stat.last_voice) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (act_ff == psvb_pkg::ACT_SET) cmd.apply_set = 1'b1;
            else cmd.apply_rel = 1'b1;
            state_in = ST_DONE;
         end
         ST_CLR: begin
            cmd.clear_all = 1'b1;
            state_in = ST_DONE;
         end
         ST_VOICE: begin
            if (!stat.cur_used) begin
               cmd.next_voice = 1'b1;
               if (stat.last_voice) state_in = ST_DONE;
            end else if (stat.need_div) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.voice_fin  = 1'b1;
            cmd.next_voice = 1'b1;
            state_in = stat.last_voice ? ST_DONE : ST_VOICE;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: hdl/psvb_datapath.sv
// ----------------------------------------------------------------------------
// psvb_datapath
// voice slot storage, key search, level ramp divider, sine lookup and mixer
// ----------------------------------------------------------------------------
module psvb_datapath #(
   parameter int NUM_VOICES      = psvb_pkg::NUM_VOICES_DEF,
   parameter int SINE_TABLE_BITS = psvb_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  psvb_pkg::cmd_type         cmd,
   input  logic [1:0]                req_action,
   input  logic [11:0]               req_voice_key,
   input  logic [31:0]               req_phase_step,
   input  logic [14:0]               req_target_amplitude,
   input  logic [9:0]                ramp,
   output psvb_pkg::stat_type        stat,
   output logic signed [15:0]        rsp_sample_out,
   output logic                      rsp_sample_valid,
   output logic                      rsp_status,
   output logic [4:0]                rsp_active_voices,
   output logic                      rsp_strobe
);

   localparam int VW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int TS  = 1 << SINE_TABLE_BITS;
   localparam int CW  = $clog2(NUM_VOICES + 1);
   localparam int AW  = 16 + VW + 1;

   logic [NUM_VOICES-1:0] used_ff, used_in;
   logic [11:0] key_mem   [NUM_VOICES];
   logic [31:0] phase_mem [NUM_VOICES];
   logic [31:0] step_mem  [NUM_VOICES];
   logic [31:0] level_mem [NUM_VOICES];
   logic [14:0] tgt_mem   [NUM_VOICES];

   logic [VW-1:0] ptr_ff;
   logic [11:0]   key_ff;
   logic [31:0]   step_ff;
   logic [14:0]   tgt_ff;
   logic          tick_ff;
   logic          found_ff, free_ok_ff;
   logic [VW-1:0] found_idx_ff, free_idx_ff;
   logic          status_ff;
   logic signed [AW-1:0] acc_ff;

   // restoring divider of |diff| by ramp
   logic [31:0] rem_ff, quo_ff;
   logic [5:0]  dcnt_ff;
   logic        dneg_ff;

   logic [31:0] cur_level, cur_phase;
   logic [14:0] cur_tgt;
   logic signed [32:0] diff;
   logic [32:0] mag;
   logic [9:0]  ramp_eff;

   assign cur_level = level_mem[ptr_ff];
   assign cur_phase = phase_mem[ptr_ff];
   assign cur_tgt   = tgt_mem[ptr_ff];
   assign ramp_eff  = (ramp == 10'd0) ? 10'd1 : ramp;
   assign diff = $signed({1'b0, cur_tgt, 16'd0}) - $signed({1'b0, cur_level});
   assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

   assign stat.cur_used   = used_ff[ptr_ff];
   assign stat.need_div   = (mag > {1'b0, psvb_pkg::LEVEL_EPS});
   assign stat.div_done   = (dcnt_ff == 6'd1);
   assign stat.last_voice = (ptr_ff == VW'(NUM_VOICES - 1));

   // next level from the divider quotient
   logic [31:0] new_level;
   always_comb begin
      if (quo_ff == 32'd0) new_level = {1'b0, cur_tgt, 16'd0};
      else if (dneg_ff) new_level = cur_level - quo_ff;
      else new_level = cur_level + quo_ff;
   end

   // sine table read is registered; the pointer sits on a voice in the voice state
   // before voice_fin, so the entry is ready in time
   logic [SINE_TABLE_BITS-1:0] sidx;
   logic signed [15:0] sine_rom [TS];
   logic signed [15:0] sine_ff;
   logic [31:0] lvl_use;
   logic signed [48:0] prod;
   logic signed [48:0] contrib;

   initial begin
      for (int i = 0; i < TS; i++) sine_rom[i] = psvb_pkg::sine_entry(i, SINE_TABLE_BITS);
   end

   assign sidx = cur_phase[31 -: SINE_TABLE_BITS];

   always_ff @(posedge clock) begin
      sine_ff <= sine_rom[sidx];
   end

   assign lvl_use = stat.need_div ? new_level : cur_level;
   assign prod = sine_ff * $signed({1'b0, lvl_use});
   // truncate toward zero
   assign contrib = (prod < 0) ? -((-prod) >>> 31) : (prod >>> 31);

   logic [CW-1:0] cnt;
   always_comb begin
      cnt = '0;
      for (int i = 0; i < NUM_VOICES; i++) cnt = cnt + CW'(used_in[i]);
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.clear_all) used_in = '0;
      if (cmd.apply_set && !found_ff && free_ok_ff) used_in[free_idx_ff] = 1'b1;
      if (cmd.voice_fin && lvl_use <= psvb_pkg::LEVEL_FREE_MAX
          && cur_tgt <= psvb_pkg::TARGET_FREE_MAX) used_in[ptr_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         ptr_ff     <= '0;
         dcnt_ff    <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         used_ff    <= used_in;
         rsp_strobe <= cmd.finish;
         if (cmd.load) ptr_ff <= '0;
         else if (cmd.next_voice)
            ptr_ff <= stat.last_voice ? '0 : VW'(ptr_ff + 1'b1);
         if (cmd.div_start) dcnt_ff <= 6'd32;
         else if (cmd.div_step && dcnt_ff != 6'd0) dcnt_ff <= dcnt_ff - 6'd1;
      end
   end

   logic [32:0] trial;
   assign trial = {rem_ff, quo_ff[31]} - {23'd0, ramp_eff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff     <= req_voice_key;
         step_ff    <= req_phase_step;
         tgt_ff     <= req_target_amplitude;
         tick_ff    <= (req_action == psvb_pkg::ACT_TICK);
         found_ff   <= 1'b0;
         free_ok_ff <= 1'b0;
         status_ff  <= 1'b0;
         acc_ff     <= '0;
      end
      if (cmd.scan_step) begin
         if (used_ff[ptr_ff] && key_mem[ptr_ff] == key_ff && !found_ff) begin
            found_ff     <= 1'b1;
            found_idx_ff <= ptr_ff;
         end
         if (!used_ff[ptr_ff] && !free_ok_ff) begin
            free_ok_ff  <= 1'b1;
            free_idx_ff <= ptr_ff;
         end
      end
      if (cmd.apply_set) begin
         if (found_ff) begin
            step_mem[found_idx_ff] <= step_ff;
            tgt_mem[found_idx_ff]  <= tgt_ff;
         end else if (free_ok_ff) begin
            key_mem[free_idx_ff]   <= key_ff;
            phase_mem[free_idx_ff] <= 32'd0;
            level_mem[free_idx_ff] <= 32'd0;
            step_mem[free_idx_ff]  <= step_ff;
            tgt_mem[free_idx_ff]   <= tgt_ff;
         end else begin
            status_ff <= 1'b1;
         end
      end
      if (cmd.apply_rel && found_ff) tgt_mem[found_idx_ff] <= 15'd0;
      if (cmd.div_start) begin
         // quotient register shifts the dividend in from the top
         rem_ff  <= '0;
         quo_ff  <= mag[31:0];
         dneg_ff <= diff[32];
      end else if (cmd.div_step && dcnt_ff != 6'd0) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[31]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.voice_fin) begin
         if (stat.need_div) level_mem[ptr_ff] <= new_level;
         phase_mem[ptr_ff] <= cur_phase + step_mem[ptr_ff];
         acc_ff <= acc_ff + AW'(contrib);
      end
      if (cmd.finish) begin
         rsp_sample_valid  <= tick_ff;
         rsp_status        <= status_ff;
         rsp_active_voices <= (cnt > CW'(31)) ? 5'd31 : 5'(cnt);
         if (!tick_ff) rsp_sample_out <= 16'sd0;
         else if (acc_ff > AW'(32767)) rsp_sample_out <= 16'sh7fff;
         else if (acc_ff < -AW'(32768)) rsp_sample_out <= 16'sh8000;
         else rsp_sample_out <= acc_ff[15:0];
      end
   end

   always @(posedge clock) begin
      if (!reset && cmd.apply_set && cmd.voice_fin)
         $error("set and tick overlap");
   end

endmodule

FILE: hdl/polyphonic_sine_voice_bank.sv
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_bank
// keyed bank of sine voices with level ramp, mixed to one saturated sample
// ----------------------------------------------------------------------------
// channel   direction  handshake
// req_*     in         start high and busy low accepts a transaction
// rsp_*     out        rsp_strobe marks a one-cycle result transaction
// csr_*     in/out     apb write at psel & penable & pwrite, pready tied high
//
// a tick visits every slot: an empty slot only passes the voice state, a slot without
// a level change adds fin, one with a change also runs the 32-step restoring divider
// of the level difference; set and release scan all slots once, then apply
// clear-all frees every slot, then done; the result follows in the cycle after done
// synchronous reset empties the bank and sets ramp_samples to 353
// the receiver cannot stall; results are never held
module polyphonic_sine_voice_bank #(
   parameter int NUM_VOICES      = psvb_pkg::NUM_VOICES_DEF,
   parameter int SINE_TABLE_BITS = psvb_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [11:0]        req_voice_key,
   input  logic [31:0]        req_phase_step,
   input  logic [14:0]        req_target_amplitude,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_sample_out,
   output logic               rsp_sample_valid,
   output logic               rsp_status,
   output logic [4:0]         rsp_active_voices,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   psvb_pkg::cmd_type  cmd;
   psvb_pkg::stat_type stat;
   logic [9:0] ramp_ff;

   assign pready = 1'b1;

   // ramp register lives at byte address 0
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff <= psvb_pkg::RAMP_RESET;
      end else if (psel && penable && pwrite && paddr == 2'd0) begin
         ramp_ff <= pwdata[9:0];
      end
   end

   assign prdata = (paddr == 2'd0) ? {22'd0, ramp_ff} : 32'd0;

   psvb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_action(req_action),
      .stat(stat), .cmd(cmd), .busy(busy)
   );

   psvb_datapath #(
      .NUM_VOICES(NUM_VOICES), .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_action(req_action),
      .req_voice_key(req_voice_key), .req_phase_step(req_phase_step),
      .req_target_amplitude(req_target_amplitude), .ramp(ramp_ff),
      .stat(stat), .rsp_sample_out(rsp_sample_out),
      .rsp_sample_valid(rsp_sample_valid), .rsp_status(rsp_status),
      .rsp_active_voices(rsp_active_voices), .rsp_strobe(rsp_strobe)
   );

   // no result strobe directly follows an accepted transaction
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$past(start && !busy)) else $error("strobe right after accept");
   // an accept makes the bank busy
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after accept");
   // a non-tick result carries no sample
   a_zero_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_sample_valid) |-> rsp_sample_out == 16'sd0)
      else $error("sample on non-tick");

endmodule
